>>> sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define LMTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define LMTC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define LMTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lmtc_pkg.sv
package lmtc_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_WR_CTRL  = 2'd1,
        OP_WR_STAT  = 2'd2
    } op_t;

    // display modes as seen in the status register
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_COMPARE = 2'd0;
    localparam logic [1:0] CFG_WINDOW_TOP   = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LEFT  = 2'd2;

    // line timing
    localparam logic [8:0] DOTS_SEARCH_END = 9'd80;
    localparam logic [8:0] DOTS_XFER_END   = 9'd252;
    localparam logic [8:0] DOTS_PER_LINE   = 9'd456;
    localparam logic [7:0] LINE_VBLANK     = 8'd144;
    localparam logic [7:0] LINES_PER_FRAME = 8'd154;
    localparam logic [7:0] WINDOW_X_LIMIT  = 8'd166;
    localparam logic [2:0] ENABLE_DELAY_TICKS = 3'd4;
    localparam logic [5:0] LAST_PAIR_INDEX = 6'd39;
    localparam logic [15:0] WINDOW_MAX     = 16'hFFFF;

    // control register bits
    localparam int CTRL_LCD_ON  = 7;
    localparam int CTRL_WIN_ON  = 5;

    // status interrupt enables, bits 3..6 of the status register
    localparam int EN_HBLANK  = 0;
    localparam int EN_VBLANK  = 1;
    localparam int EN_SEARCH  = 2;
    localparam int EN_COMPARE = 3;

    // one result item
    typedef struct packed {
        logic [7:0]  line_number;
        logic [1:0]  mode_now;
        logic [7:0]  status_read;
        logic [7:0]  control_read;
        logic        vblank_irq;
        logic        stat_irq;
        logic        render_strobe;
        logic [15:0] window_line;
        logic [5:0]  search_pair_index;
        logic [5:0]  frozen_pair_index;
    } result_t;

endpackage

>>> sv/lcd_mode_timing_controller.sv
// each result is registered: into the output register, or into the skid while a stalled result waits
// throughput: one item per clock unless in_stall; one pass of logic between state and result
// a two-entry output stage (result register plus skid) keeps input open while a result waits
// reset: asynchronous, active low; display off, line 0, mode 0, status 0x80, config zero
`include "assert_macros.svh"

module lcd_mode_timing_controller (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  write_data,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  line_number,
    output logic [1:0]  mode_now,
    output logic [7:0]  status_read,
    output logic [7:0]  control_read,
    output logic        vblank_irq,
    output logic        stat_irq,
    output logic        render_strobe,
    output logic [15:0] window_line,
    output logic [5:0]  search_pair_index,
    output logic [5:0]  frozen_pair_index
);
    import lmtc_pkg::*;

    // configuration registers
    logic [7:0] line_compare_reg;
    logic [7:0] window_top_reg;
    logic [7:0] window_left_reg;

    // timing state
    logic [7:0]  ctrl_reg,     ctrl_next;
    logic [3:0]  stat_en_reg,  stat_en_next;
    logic        coinc_reg,    coinc_next;
    logic [7:0]  line_reg,     line_next;
    logic [8:0]  dot_reg,      dot_next;
    mode_t       mode_reg,     mode_next;
    logic        pending_reg,  pending_next;
    logic [2:0]  delay_reg,    delay_next;
    logic [15:0] win_cnt_reg,  win_cnt_next;
    logic [5:0]  pair_reg,     pair_next;
    logic [5:0]  latched_reg,  latched_next;

    // output stage
    result_t out_reg, skid_reg, result;
    logic    out_valid_reg, skid_valid_reg;

    logic    in_xfer;
    logic    out_xfer;
    logic    vb_pulse, st_pulse, rs_pulse;
    mode_t   nm;
    logic [8:0] dot_inc;
    logic [7:0] old_line;

    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_xfer = out_valid_reg && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_compare_reg <= '0;
            window_top_reg   <= '0;
            window_left_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINE_COMPARE: line_compare_reg <= cfg_data;
                CFG_WINDOW_TOP:   window_top_reg   <= cfg_data;
                CFG_WINDOW_LEFT:  window_left_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // next state and pulses for one item
    always_comb
    begin
        ctrl_next    = ctrl_reg;
        stat_en_next = stat_en_reg;
        coinc_next   = coinc_reg;
        line_next    = line_reg;
        dot_next     = dot_reg;
        mode_next    = mode_reg;
        pending_next = pending_reg;
        delay_next   = delay_reg;
        win_cnt_next = win_cnt_reg;
        pair_next    = pair_reg;
        latched_next = latched_reg;
        vb_pulse     = 1'b0;
        st_pulse     = 1'b0;
        rs_pulse     = 1'b0;
        nm           = MODE_HBLANK;
        dot_inc      = '0;
        old_line     = line_reg;

        case (op_t'(opcode))
            OP_TICK:
            begin
                // enable countdown runs on every tick
                if (pending_reg)
                begin
                    if (delay_reg != 3'd0)
                        delay_next = delay_reg - 3'd1;
                    if (delay_next == 3'd0)
                    begin
                        pending_next = 1'b0;
                        dot_next     = '0;
                        mode_next    = MODE_SEARCH;
                    end
                end

                if (!ctrl_reg[CTRL_LCD_ON])
                begin
                    // display off holds line 0 in hblank
                    line_next = '0;
                    mode_next = MODE_HBLANK;
                end
                else
                begin
                    // mode from line and dot position
                    if (line_reg >= LINE_VBLANK)
                        nm = MODE_VBLANK;
                    else if (dot_next < DOTS_SEARCH_END)
                        nm = MODE_SEARCH;
                    else if (dot_next < DOTS_XFER_END)
                        nm = MODE_XFER;
                    else
                        nm = MODE_HBLANK;

                    // mode entry events
                    if (nm != mode_next)
                    begin
                        mode_next = nm;
                        case (nm)
                            MODE_SEARCH: st_pulse = stat_en_reg[EN_SEARCH];
                            MODE_XFER:
                            begin
                                rs_pulse     = 1'b1;
                                latched_next = pair_reg;
                            end
                            MODE_HBLANK: st_pulse = stat_en_reg[EN_HBLANK];
                            default:
                            begin
                                if (line_reg == LINE_VBLANK)
                                begin
                                    vb_pulse = 1'b1;
                                    st_pulse = stat_en_reg[EN_VBLANK];
                                end
                            end
                        endcase
                    end

                    // sprite pair tracking during the oam scan
                    if (mode_next == MODE_SEARCH)
                        pair_next = (dot_next < DOTS_SEARCH_END) ? dot_next[6:1]
                                                                 : LAST_PAIR_INDEX;
                    else if (mode_next != MODE_XFER)
                        pair_next = '0;

                    // dot advance and line end
                    dot_inc = dot_next + 9'd1;
                    dot_next = dot_inc;
                    if (dot_inc >= DOTS_PER_LINE)
                    begin
                        dot_next  = '0;
                        line_next = line_reg + 8'd1;
                        if (ctrl_reg[CTRL_WIN_ON] && old_line < LINE_VBLANK
                            && old_line >= window_top_reg
                            && window_left_reg <= WINDOW_X_LIMIT
                            && win_cnt_reg != WINDOW_MAX)
                            win_cnt_next = win_cnt_reg + 16'd1;
                        if (line_next == line_compare_reg)
                        begin
                            coinc_next = 1'b1;
                            if (stat_en_reg[EN_COMPARE])
                                st_pulse = 1'b1;
                        end
                        else
                        begin
                            coinc_next = 1'b0;
                        end
                        // frame wrap
                        if (line_next >= LINES_PER_FRAME)
                        begin
                            line_next    = '0;
                            mode_next    = MODE_SEARCH;
                            win_cnt_next = '0;
                            if (stat_en_reg[EN_SEARCH])
                                st_pulse = 1'b1;
                        end
                    end
                end
            end

            OP_WR_CTRL:
            begin
                ctrl_next = write_data;
                if (!ctrl_reg[CTRL_LCD_ON] && write_data[CTRL_LCD_ON])
                begin
                    // enable edge
                    pending_next = 1'b1;
                    delay_next   = ENABLE_DELAY_TICKS;
                    line_next    = '0;
                    mode_next    = MODE_HBLANK;
                end
                else if (ctrl_reg[CTRL_LCD_ON] && !write_data[CTRL_LCD_ON])
                begin
                    // disable edge
                    line_next    = '0;
                    dot_next     = '0;
                    mode_next    = MODE_HBLANK;
                    win_cnt_next = '0;
                end
                if (!ctrl_reg[CTRL_WIN_ON] && write_data[CTRL_WIN_ON])
                    win_cnt_next = '0;
            end

            OP_WR_STAT:
            begin
                stat_en_next = write_data[6:3];
            end

            default: ;
        endcase
    end

    // state update on input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= '0;
            stat_en_reg <= '0;
            coinc_reg   <= 1'b0;
            line_reg    <= '0;
            dot_reg     <= '0;
            mode_reg    <= MODE_HBLANK;
            pending_reg <= 1'b0;
            delay_reg   <= '0;
            win_cnt_reg <= '0;
            pair_reg    <= '0;
            latched_reg <= '0;
        end
        else if (in_xfer)
        begin
            ctrl_reg    <= ctrl_next;
            stat_en_reg <= stat_en_next;
            coinc_reg   <= coinc_next;
            line_reg    <= line_next;
            dot_reg     <= dot_next;
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            delay_reg   <= delay_next;
            win_cnt_reg <= win_cnt_next;
            pair_reg    <= pair_next;
            latched_reg <= latched_next;
        end
    end

    // result of the item being accepted
    always_comb
    begin
        result.line_number       = line_next;
        result.mode_now          = mode_next;
        result.status_read       = {1'b1, stat_en_next, coinc_next, mode_next};
        result.control_read      = ctrl_next;
        result.vblank_irq        = vb_pulse;
        result.stat_irq          = st_pulse;
        result.render_strobe     = rs_pulse;
        result.window_line       = win_cnt_next;
        result.search_pair_index = pair_next;
        result.frozen_pair_index = latched_next;
    end

    // output register and skid stage, valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_xfer || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_xfer;
            skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage, payload
    always_ff @(posedge clk)
    begin
        if (out_xfer || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_xfer)
                out_reg <= result;
        end
        else if (in_xfer)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign line_number       = out_reg.line_number;
    assign mode_now          = out_reg.mode_now;
    assign status_read       = out_reg.status_read;
    assign control_read      = out_reg.control_read;
    assign vblank_irq        = out_reg.vblank_irq;
    assign stat_irq          = out_reg.stat_irq;
    assign render_strobe     = out_reg.render_strobe;
    assign window_line       = out_reg.window_line;
    assign search_pair_index = out_reg.search_pair_index;
    assign frozen_pair_index = out_reg.frozen_pair_index;

    // checks
    `LMTC_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `LMTC_ASSERT_ALWAYS(a_line_in_frame, line_reg < LINES_PER_FRAME, "line counter beyond frame")
    `LMTC_ASSERT_IMPLIES(a_vblank_pulse, out_valid_reg && out_reg.vblank_irq, out_reg.line_number == LINE_VBLANK && out_reg.mode_now == MODE_VBLANK, "vblank pulse off line 144")
    `LMTC_ASSERT_IMPLIES(a_render_mode, out_valid_reg && out_reg.render_strobe, out_reg.mode_now == MODE_XFER, "render strobe outside pixel transfer")
    `LMTC_ASSERT_NEXT(a_stall_holds_skid, skid_valid_reg && out_stall, skid_valid_reg && out_valid_reg, "skid lost while stalled")

endmodule

>>> dv/lmtc_timing_checker.sv
`timescale 1ns / 100ps

module lmtc_timing_checker
    import lmtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  line_number,
    input  logic [1:0]  mode_now,
    input  logic [7:0]  status_read,
    input  logic [7:0]  control_read,
    input  logic        vblank_irq,
    input  logic        stat_irq,
    input  logic        render_strobe,
    input  logic [15:0] window_line,
    input  logic [5:0]  search_pair_index,
    input  logic [5:0]  frozen_pair_index,
    output int          mismatch_count,
    output int          states_outstanding
);

    // status register bits
    localparam logic [7:0] STAT_KEPT_BITS     = 8'h87;
    localparam logic [7:0] STAT_WRITABLE_BITS = 8'h78;
    localparam logic [7:0] STAT_READ_SET      = 8'h80;
    localparam int         STAT_COINCIDENCE   = 2;
    localparam int         STAT_ENABLE_BASE   = 3;

    // shadow of the configuration registers
    logic [7:0]  compare_line;
    logic [7:0]  win_top;
    logic [7:0]  win_left;

    // shadow of the display state
    logic [7:0]  ctrl_shadow;
    logic [7:0]  stat_shadow;
    logic [7:0]  line_count;
    logic [8:0]  dot_count;
    mode_t       mode_shadow;
    logic        enable_waiting;
    logic [2:0]  enable_countdown;
    logic [15:0] window_count;
    logic [5:0]  pair_now;
    logic [5:0]  pair_frozen;

    // display states owed by the block, oldest first
    result_t     display_states_due[$];

    // mode change mirrored into the low status bits
    task automatic put_mode(input mode_t m);
        mode_shadow = m;
        stat_shadow[1:0] = m;
    endtask

    task automatic apply_control_write(input logic [7:0] v);
        logic turn_on;
        logic turn_off;
        logic win_rise;
        turn_on  = !ctrl_shadow[CTRL_LCD_ON] && v[CTRL_LCD_ON];
        turn_off = ctrl_shadow[CTRL_LCD_ON] && !v[CTRL_LCD_ON];
        win_rise = !ctrl_shadow[CTRL_WIN_ON] && v[CTRL_WIN_ON];
        ctrl_shadow = v;
        if (turn_on)
        begin
            enable_waiting = 1'b1;
            enable_countdown = ENABLE_DELAY_TICKS;
            line_count = '0;
            put_mode(MODE_HBLANK);
        end
        else if (turn_off)
        begin
            line_count = '0;
            dot_count = '0;
            put_mode(MODE_HBLANK);
            window_count = '0;
        end
        if (win_rise)
            window_count = '0;
    endtask

    // one display dot
    task automatic advance_dot(output logic vb, output logic st, output logic rs);
        mode_t      next_mode;
        logic [7:0] prev_line;
        vb = 1'b0;
        st = 1'b0;
        rs = 1'b0;
        // enable countdown runs whether or not the display is on
        if (enable_waiting)
        begin
            if (enable_countdown != 0)
                enable_countdown = enable_countdown - 1'b1;
            if (enable_countdown == 0)
            begin
                enable_waiting = 1'b0;
                dot_count = '0;
                put_mode(MODE_SEARCH);
            end
        end
        if (!ctrl_shadow[CTRL_LCD_ON])
        begin
            line_count = '0;
            put_mode(MODE_HBLANK);
            return;
        end
        // mode from position in the frame
        if (line_count >= LINE_VBLANK)
            next_mode = MODE_VBLANK;
        else if (dot_count < DOTS_SEARCH_END)
            next_mode = MODE_SEARCH;
        else if (dot_count < DOTS_XFER_END)
            next_mode = MODE_XFER;
        else
            next_mode = MODE_HBLANK;
        if (next_mode != mode_shadow)
        begin
            put_mode(next_mode);
            case (next_mode)
                MODE_SEARCH: st = stat_shadow[STAT_ENABLE_BASE + EN_SEARCH];
                MODE_XFER:
                begin
                    rs = 1'b1;
                    pair_frozen = pair_now;
                end
                MODE_HBLANK: st = stat_shadow[STAT_ENABLE_BASE + EN_HBLANK];
                default:
                begin
                    if (line_count == LINE_VBLANK)
                    begin
                        vb = 1'b1;
                        st = stat_shadow[STAT_ENABLE_BASE + EN_VBLANK];
                    end
                end
            endcase
        end
        // sprite pair follows the scan
        if (mode_shadow == MODE_SEARCH)
            pair_now = (dot_count < DOTS_SEARCH_END) ? 6'(dot_count >> 1) : LAST_PAIR_INDEX;
        else if (mode_shadow != MODE_XFER)
            pair_now = '0;
        // line end
        dot_count = dot_count + 1'b1;
        if (dot_count >= DOTS_PER_LINE)
        begin
            prev_line = line_count;
            dot_count = '0;
            line_count = line_count + 1'b1;
            if (ctrl_shadow[CTRL_WIN_ON] && prev_line < LINE_VBLANK && prev_line >= win_top &&
                win_left <= WINDOW_X_LIMIT && window_count < WINDOW_MAX)
                window_count = window_count + 1'b1;
            if (line_count == compare_line)
            begin
                stat_shadow[STAT_COINCIDENCE] = 1'b1;
                if (stat_shadow[STAT_ENABLE_BASE + EN_COMPARE])
                    st = 1'b1;
            end
            else
                stat_shadow[STAT_COINCIDENCE] = 1'b0;
            // frame wrap goes straight to the search mode
            if (line_count >= LINES_PER_FRAME)
            begin
                line_count = '0;
                put_mode(MODE_SEARCH);
                window_count = '0;
                if (stat_shadow[STAT_ENABLE_BASE + EN_SEARCH])
                    st = 1'b1;
            end
        end
    endtask

    // display state after one event
    task automatic take_display_event(input logic [1:0] op, input logic [7:0] data,
                                      output result_t res);
        logic vb;
        logic st;
        logic rs;
        vb = 1'b0;
        st = 1'b0;
        rs = 1'b0;
        case (op)
            OP_TICK:    advance_dot(vb, st, rs);
            OP_WR_CTRL: apply_control_write(data);
            OP_WR_STAT: stat_shadow = (stat_shadow & STAT_KEPT_BITS) | (data & STAT_WRITABLE_BITS);
            default:    ;
        endcase
        res.line_number       = line_count;
        res.mode_now          = mode_shadow;
        res.status_read       = stat_shadow | STAT_READ_SET;
        res.control_read      = ctrl_shadow;
        res.vblank_irq        = vb;
        res.stat_irq          = st;
        res.render_strobe     = rs;
        res.window_line       = window_count;
        res.search_pair_index = pair_now;
        res.frozen_pair_index = pair_frozen;
    endtask

    function automatic int field_wrong(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next_state;
        if (!rst_n)
        begin
            compare_line = '0;
            win_top = '0;
            win_left = '0;
            ctrl_shadow = '0;
            stat_shadow = STAT_READ_SET;
            line_count = '0;
            dot_count = '0;
            mode_shadow = MODE_HBLANK;
            enable_waiting = 1'b0;
            enable_countdown = '0;
            window_count = '0;
            pair_now = '0;
            pair_frozen = '0;
            mismatch_count = 0;
            display_states_due.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_LINE_COMPARE: compare_line = cfg_data;
                    CFG_WINDOW_TOP:   win_top = cfg_data;
                    CFG_WINDOW_LEFT:  win_left = cfg_data;
                    default:          ;
                endcase
            end
            // result transfer against the oldest owed state
            if (out_valid && !out_stall)
            begin
                if (display_states_due.size() == 0)
                begin
                    $display("%0t: result expected none got line %0d mode %0d", $time,
                             line_number, mode_now);
                    mismatch_count++;
                end
                else
                begin
                    want = display_states_due.pop_front();
                    mismatch_count += field_wrong("line_number", want.line_number, line_number)
                        + field_wrong("mode_now", want.mode_now, mode_now)
                        + field_wrong("status_read", want.status_read, status_read)
                        + field_wrong("control_read", want.control_read, control_read)
                        + field_wrong("vblank_irq", want.vblank_irq, vblank_irq)
                        + field_wrong("stat_irq", want.stat_irq, stat_irq)
                        + field_wrong("render_strobe", want.render_strobe, render_strobe)
                        + field_wrong("window_line", want.window_line, window_line)
                        + field_wrong("search_pair_index", want.search_pair_index,
                                      search_pair_index)
                        + field_wrong("frozen_pair_index", want.frozen_pair_index,
                                      frozen_pair_index);
                end
            end
            // event transfer, appended behind the states already owed
            if (in_valid && !in_stall)
            begin
                take_display_event(opcode, write_data, next_state);
                display_states_due.insert(display_states_due.size(), next_state);
            end
        end
        states_outstanding = display_states_due.size();
    end

endmodule

>>> dv/tb_lcd_mode_timing_controller.sv
`timescale 1ns / 100ps

module tb_lcd_mode_timing_controller;
    import lmtc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [7:0] LCD_ON_MASK = 8'h01 << CTRL_LCD_ON;
    localparam logic [7:0] WIN_ON_MASK = 8'h01 << CTRL_WIN_ON;
    localparam logic [7:0] ALL_STAT_EN = 8'h78;
    localparam int LINE_ITEMS   = 470;
    localparam int MIXED_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  line_number;
    logic [1:0]  mode_now;
    logic [7:0]  status_read;
    logic [7:0]  control_read;
    logic        vblank_irq;
    logic        stat_irq;
    logic        render_strobe;
    logic [15:0] window_line;
    logic [5:0]  search_pair_index;
    logic [5:0]  frozen_pair_index;

    int mismatch_count;
    int states_outstanding;
    int burst_left = 0;
    int delivered = 0;

    always #1 clk = ~clk;

    lcd_mode_timing_controller u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .line_number       (line_number),
        .mode_now          (mode_now),
        .status_read       (status_read),
        .control_read      (control_read),
        .vblank_irq        (vblank_irq),
        .stat_irq          (stat_irq),
        .render_strobe     (render_strobe),
        .window_line       (window_line),
        .search_pair_index (search_pair_index),
        .frozen_pair_index (frozen_pair_index)
    );

    lmtc_timing_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .opcode             (opcode),
        .write_data         (write_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .line_number        (line_number),
        .mode_now           (mode_now),
        .status_read        (status_read),
        .control_read       (control_read),
        .vblank_irq         (vblank_irq),
        .stat_irq           (stat_irq),
        .render_strobe      (render_strobe),
        .window_line        (window_line),
        .search_pair_index  (search_pair_index),
        .frozen_pair_index  (frozen_pair_index),
        .mismatch_count     (mismatch_count),
        .states_outstanding (states_outstanding)
    );

    // one event transfer, sent in bursts with random gaps
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        opcode <= op;
        write_data <= data;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        burst_left--;
    endtask

    // all three registers on consecutive cycles
    task automatic load_settings(input logic [7:0] lc, input logic [7:0] wt, input logic [7:0] wl);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_COMPARE;
        cfg_data <= lc;
        @(negedge clk);
        cfg_index <= CFG_WINDOW_TOP;
        cfg_data <= wt;
        @(negedge clk);
        cfg_index <= CFG_WINDOW_LEFT;
        cfg_data <= wl;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // stop sending and wait until every owed result has come back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (states_outstanding != 0);
        repeat (2) @(negedge clk);
    endtask

    // long runs of dots with the odd register write between them
    task automatic run_dots(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 999);
            if (r == 0)
                send_item(OP_WR_STAT, 8'($urandom));
            else if (r == 1)
                send_item(OP_WR_CTRL, LCD_ON_MASK | 8'($urandom));
            else
                send_item(OP_TICK, 8'($urandom));
        end
    endtask

    // count result transfers to time the long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            delivered <= delivered + 1;
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int  stretch_left;
        int  stall_pct;
        int  hold_left;
        bit  held;
        stretch_left = 0;
        stall_pct = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && delivered >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stretch_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int r;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: display off, register writes, enable and disable edges
        load_settings(8'd0, 8'd0, 8'd0);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_WR_STAT, 8'hFF);
        send_item(OP_WR_STAT, 8'h00);
        send_item(OP_WR_STAT, ALL_STAT_EN);
        send_item(OP_WR_CTRL, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_WR_CTRL, 8'hFF);
        repeat (6) send_item(OP_TICK, 8'($urandom));
        send_item(OP_WR_CTRL, 8'h7F);
        send_item(OP_TICK, 8'h00);
        send_item(OP_WR_CTRL, LCD_ON_MASK);
        repeat (2) send_item(OP_TICK, 8'($urandom));
        // disable while the enable is still counting down
        send_item(OP_WR_CTRL, 8'h00);
        repeat (3) send_item(OP_TICK, 8'($urandom));
        send_item(OP_UNUSED, 8'h00);
        settle();

        // one whole line: enable delay, line end, compare on line 1, window count at the edge
        load_settings(8'd1, 8'd0, WINDOW_X_LIMIT);
        send_item(OP_WR_STAT, ALL_STAT_EN);
        send_item(OP_WR_CTRL, LCD_ON_MASK | WIN_ON_MASK);
        run_dots(LINE_ITEMS);
        settle();

        // mixed random events at the top of every register
        load_settings(8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < MIXED_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
                send_item(OP_TICK, 8'($urandom));
            else if (r < 90)
                send_item(OP_WR_STAT, 8'($urandom));
            else if (r < 97)
                send_item(OP_WR_CTRL, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                                  : LCD_ON_MASK | 8'($urandom));
            else
                send_item(OP_UNUSED, 8'($urandom));
        end
        settle();
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb_lcd_mode_timing_controller OK");
        else
            $display("tb_lcd_mode_timing_controller NOT OK");
        $finish;
    end

    // hang guard
    initial
    begin
        #15_000_000;
        $display("tb_lcd_mode_timing_controller NOT OK");
        $finish;
    end

endmodule
